>>> rtl/ciit_pkg.sv
// ----------------------------------------------------------------------------
// ciit_pkg
// Shared types, opcodes and status codes for the chunk id index table.
// ----------------------------------------------------------------------------
package ciit_pkg;

    localparam int TABLE_ENTRIES = 4096;
    localparam int KEY_BYTES     = 32;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = IDX_W + 1;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_INVALID   = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] key_word0;
        logic [63:0] key_word1;
        logic [63:0] key_word2;
        logic [63:0] key_word3;
        logic [63:0] entry_offset;
        logic [31:0] entry_length;
    } ciit_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] found_offset;
        logic [31:0] found_length;
        logic [12:0] entry_count;
    } ciit_out_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input item
        logic write;      // write record at count, bump count
        logic clear;      // count to zero
        logic scan_start; // scan index to zero
        logic scan_read;  // issue read at scan index
        logic scan_next;  // advance scan index
        logic set_found;  // latch record data as result
    } ciit_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] operation;
        logic       len_zero;
        logic       full;
        logic       scan_end;  // scan index reached count
        logic       match;     // registered read matches key
    } ciit_stat_t;

    function automatic logic [63:0] word_mask(input int w);
        int n;
        n = KEY_BYTES - 8 * w;
        if (n >= 8)
            return '1;
        else if (n <= 0)
            return '0;
        else
            return ~64'd0 << (8 * (8 - n));
    endfunction

endpackage

>>> rtl/ciit_datapath.sv
// ----------------------------------------------------------------------------
// ciit_datapath
// Record memories, record count, linear scan index and result register.
// ----------------------------------------------------------------------------
module ciit_datapath
    import ciit_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ciit_in_t   in_item,
    input  ciit_cmd_t  cmd,
    output ciit_stat_t stat,
    output ciit_out_t  result
);

    logic [255:0] key_mem [TABLE_ENTRIES];
    logic [63:0]  off_mem [TABLE_ENTRIES];
    logic [31:0]  len_mem [TABLE_ENTRIES];

    ciit_in_t     item_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] scan_reg;
    logic [255:0] rd_key_reg;
    logic [63:0]  rd_off_reg;
    logic [31:0]  rd_len_reg;
    logic [255:0] key_in;
    logic [255:0] key_mask;
    logic [63:0]  off_reg;
    logic [31:0]  len_reg;

    assign key_in   = {item_reg.key_word0, item_reg.key_word1,
                       item_reg.key_word2, item_reg.key_word3};
    assign key_mask = {word_mask(0), word_mask(1), word_mask(2), word_mask(3)};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= in_item;
        if (cmd.write)
        begin
            key_mem[count_reg[IDX_W-1:0]] <= key_in;
            off_mem[count_reg[IDX_W-1:0]] <= item_reg.entry_offset;
            len_mem[count_reg[IDX_W-1:0]] <= item_reg.entry_length;
        end
        if (cmd.scan_read)
        begin
            rd_key_reg <= key_mem[scan_reg[IDX_W-1:0]];
            rd_off_reg <= off_mem[scan_reg[IDX_W-1:0]];
            rd_len_reg <= len_mem[scan_reg[IDX_W-1:0]];
        end
        if (cmd.load)
        begin
            off_reg <= '0;
            len_reg <= '0;
        end
        else if (cmd.set_found)
        begin
            off_reg <= rd_off_reg;
            len_reg <= rd_len_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            scan_reg  <= '0;
        end
        else
        begin
            if (cmd.clear)
                count_reg <= '0;
            else if (cmd.write)
                count_reg <= count_reg + 1'b1;
            if (cmd.scan_start)
                scan_reg <= '0;
            else if (cmd.scan_next)
                scan_reg <= scan_reg + 1'b1;
        end
    end

    assign stat.operation = item_reg.operation;
    assign stat.len_zero  = (item_reg.entry_length == '0);
    assign stat.full      = (count_reg >= CNT_W'(TABLE_ENTRIES));
    assign stat.scan_end  = (scan_reg >= count_reg);
    assign stat.match     = ((rd_key_reg & key_mask) == (key_in & key_mask));

    assign result.status       = ST_OK;
    assign result.found_offset = off_reg;
    assign result.found_length = len_reg;
    assign result.entry_count  = 13'(count_reg);

endmodule

>>> rtl/ciit_ctrl.sv
// ----------------------------------------------------------------------------
// ciit_ctrl
// Operation sequencer: decodes the item, runs the scan, holds the result.
// ----------------------------------------------------------------------------
module ciit_ctrl
    import ciit_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  ciit_stat_t stat,
    output ciit_cmd_t  cmd,
    output logic [1:0] status
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_READ  = 5'b00100,
        S_CMP   = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] status_reg, status_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign status    = status_reg;

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                case (stat.operation)
                    OP_INSERT:
                    begin
                        if (stat.len_zero)
                            status_next = ST_INVALID;
                        else if (stat.full)
                            status_next = ST_FULL;
                        else
                        begin
                            status_next = ST_OK;
                            cmd.write   = 1'b1;
                        end
                    end
                    OP_QUERY:
                    begin
                        status_next    = ST_NOT_FOUND;
                        cmd.scan_start = 1'b1;
                        state_next     = S_READ;
                    end
                    OP_CLEAR:
                    begin
                        status_next = ST_OK;
                        cmd.clear   = 1'b1;
                    end
                    default:
                        status_next = ST_INVALID;
                endcase
            end
            S_READ:
            begin
                if (stat.scan_end)
                    state_next = S_DONE;
                else
                begin
                    cmd.scan_read = 1'b1;
                    cmd.scan_next = 1'b1;
                    state_next    = S_CMP;
                end
            end
            S_CMP:
            begin
                if (stat.match)
                begin
                    cmd.set_found = 1'b1;
                    status_next   = ST_OK;
                    state_next    = S_DONE;
                end
                else
                    state_next = S_READ;
            end
            S_DONE:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    a_one_hot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state not one-hot");
    a_write_insert: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |-> stat.operation == OP_INSERT && !stat.full && !stat.len_zero)
        else $error("bad write");
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set_found |=> status_reg == ST_OK && state_reg == S_DONE)
        else $error("found without ok");

endmodule

>>> rtl/chunk_id_index_table_unit.sv
// ----------------------------------------------------------------------------
// chunk_id_index_table_unit
// Append-only chunk record table with exact-id lookup and clear.
// ----------------------------------------------------------------------------
// channel  dir  handshake            payload
// in       in   in_valid/in_ready    ciit_in_t
// out      out  out_valid/out_ready  ciit_out_t
//
// query scans records in insert order over the single read port, reading
// then comparing each record in turn, and stops at the first match or at
// the end of the table.
// one item at a time; a stalled result holds the next item off.
// reset empties the table; memories need no clearing pass.
// ----------------------------------------------------------------------------
module chunk_id_index_table_unit
    import ciit_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  ciit_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output ciit_out_t out_data
);

    ciit_cmd_t  cmd;
    ciit_stat_t stat;
    ciit_out_t  dp_result;
    logic [1:0] status;

    ciit_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd),
        .status    (status)
    );

    ciit_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_item (in_data),
        .cmd     (cmd),
        .stat    (stat),
        .result  (dp_result)
    );

    always_comb
    begin
        out_data        = dp_result;
        out_data.status = status;
    end

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks chunk_id_index_table_unit against an in-bench table predictor: a
// short directed list, random traffic on small tables, then a short run of
// inserts with a repeated id. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module tb;
    import ciit_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    ciit_in_t  in_data;
    logic      out_valid;
    logic      out_ready;
    ciit_out_t out_data;

    chunk_id_index_table_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // predicted table contents
    logic [63:0] tbl_key [TABLE_ENTRIES][4];
    logic [63:0] tbl_offset [TABLE_ENTRIES];
    logic [31:0] tbl_length [TABLE_ENTRIES];
    int          tbl_count;

    ciit_in_t    pending_items[$];
    ciit_out_t   expected_results[$];
    logic [63:0] key_pool [8][4];
    int          mismatches;
    int          unexpected;
    int          gap_left;
    int          burst_left;
    int          cycle_cnt;
    int          stall_mode;

    initial begin
        clk = 1'b0;
        forever
        begin
            #5 clk = 1'b1;
            #5 clk = 1'b0;
        end
    end

    initial begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic logic [63:0] id_mask(input int w);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++)
            if (8 * w + b < KEY_BYTES)
                m[63 - 8 * b -: 8] = 8'hff;
        return m;
    endfunction

    function automatic ciit_out_t table_lookup_result(input ciit_in_t it);
        ciit_out_t r;
        logic      hit;
        r = '0;
        r.status = ST_OK;
        if (it.operation == OP_INSERT)
        begin
            if (it.entry_length == 0)
                r.status = ST_INVALID;
            else if (tbl_count >= TABLE_ENTRIES)
                r.status = ST_FULL;
            else
            begin
                tbl_key[tbl_count][0] = it.key_word0;
                tbl_key[tbl_count][1] = it.key_word1;
                tbl_key[tbl_count][2] = it.key_word2;
                tbl_key[tbl_count][3] = it.key_word3;
                tbl_offset[tbl_count] = it.entry_offset;
                tbl_length[tbl_count] = it.entry_length;
                tbl_count++;
            end
        end
        else if (it.operation == OP_QUERY)
        begin
            r.status = ST_NOT_FOUND;
            for (int e = 0; e < tbl_count; e++)
            begin
                hit = ((tbl_key[e][0] ^ it.key_word0) & id_mask(0)) == 0 &&
                      ((tbl_key[e][1] ^ it.key_word1) & id_mask(1)) == 0 &&
                      ((tbl_key[e][2] ^ it.key_word2) & id_mask(2)) == 0 &&
                      ((tbl_key[e][3] ^ it.key_word3) & id_mask(3)) == 0;
                if (hit)
                begin
                    r.status = ST_OK;
                    r.found_offset = tbl_offset[e];
                    r.found_length = tbl_length[e];
                    break;
                end
            end
        end
        else if (it.operation == OP_CLEAR)
            tbl_count = 0;
        else
            r.status = ST_INVALID;
        r.entry_count = tbl_count[12:0];
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic push_item(input logic [1:0] op, input logic [63:0] k0,
                             input logic [63:0] k1, input logic [63:0] k2,
                             input logic [63:0] k3, input logic [63:0] offs,
                             input logic [31:0] len);
        ciit_in_t it;
        it.operation    = op;
        it.key_word0    = k0;
        it.key_word1    = k1;
        it.key_word2    = k2;
        it.key_word3    = k3;
        it.entry_offset = offs;
        it.entry_length = len;
        pending_items.push_back(it);
    endtask

    task automatic push_random_item();
        logic [63:0] k [4];
        logic [1:0]  op;
        logic [31:0] len;
        int          sel;
        int          p;
        sel = $urandom_range(99);
        if (sel < 45)
            op = OP_INSERT;
        else if (sel < 90)
            op = OP_QUERY;
        else if (sel < 96)
            op = OP_CLEAR;
        else
            op = 2'd3;
        p = $urandom_range(7);
        for (int w = 0; w < 4; w++)
            k[w] = key_pool[p][w];
        sel = $urandom_range(9);
        if (sel < 2)
            for (int w = 0; w < 4; w++)
                k[w] = rand64();
        else if (sel < 4)
            k[$urandom_range(3)][$urandom_range(63)] ^= 1'b1;
        len = $urandom;
        if ($urandom_range(19) == 0)
            len = '0;
        else if ($urandom_range(9) == 0)
            len = 32'd1;
        push_item(op, k[0], k[1], k[2], k[3], rand64(), len);
    endtask

    initial begin
        logic [63:0] ones;
        logic [63:0] a;
        ones = '1;
        for (int p = 0; p < 8; p++)
            for (int w = 0; w < 4; w++)
                key_pool[p][w] = rand64();
        a = rand64();

        // directed: extremes, misses by one bit, repeats, bad codes
        push_item(OP_QUERY, '0, '0, '0, '0, '0, '0);
        push_item(OP_INSERT, ones, ones, ones, ones, ones, '1);
        push_item(OP_INSERT, '0, '0, '0, '0, '0, 32'd1);
        push_item(OP_INSERT, a, a, a, a, 64'd7, '0);
        push_item(OP_QUERY, ones, ones, ones, ones, '0, '0);
        push_item(OP_QUERY, '0, '0, '0, '0, ones, '1);
        push_item(OP_QUERY, a, a, a, a, '0, '0);
        push_item(OP_QUERY, ones, ones, ones, ones - 64'd1, '0, '0);
        push_item(OP_QUERY, 64'h7fff_ffff_ffff_ffff, ones, ones, ones, '0, '0);
        push_item(OP_INSERT, a, ~a, a, ~a, 64'h1234, 32'd5);
        push_item(OP_INSERT, a, ~a, a, ~a, 64'h5678, 32'd6);
        push_item(OP_QUERY, a, ~a, a, ~a, '0, '0);
        push_item(2'd3, a, a, a, a, a, 32'd9);
        push_item(2'd3, '0, '0, '0, '0, '0, '0);
        push_item(OP_CLEAR, ones, ones, ones, ones, ones, '1);
        push_item(OP_QUERY, a, ~a, a, ~a, '0, '0);
        push_item(OP_QUERY, ones, ones, ones, ones, '0, '0);
        push_item(OP_CLEAR, '0, '0, '0, '0, '0, '0);
        push_item(OP_INSERT, a, ~a, a, ~a, 64'h9, 32'd3);
        push_item(OP_QUERY, a, ~a, a, ~a, '0, '0);

        // random traffic, tables kept small by frequent clears
        for (int i = 0; i < 1270; i++)
            push_random_item();

        // short fill, with a repeated id part way through
        push_item(OP_CLEAR, '0, '0, '0, '0, '0, '0);
        for (int i = 0; i < 20; i++)
            if (i == 12)
                push_item(OP_INSERT, a, 64'd5, a, a, rand64(), $urandom | 32'd1);
            else
                push_item(OP_INSERT, a, 64'(i), a, a, rand64(), $urandom | 32'd1);
        push_item(OP_INSERT, a, ones, a, a, rand64(), 32'd4);
        push_item(OP_INSERT, a, ones, a, a, rand64(), '0);
        push_item(OP_QUERY, a, 64'd0, a, a, '0, '0);
        push_item(OP_QUERY, a, 64'd5, a, a, '0, '0);
        push_item(OP_QUERY, a, 64'd19, a, a, '0, '0);
        push_item(OP_QUERY, a, ones, a, a, '0, '0);
        push_item(2'd3, a, ones, a, a, '0, 32'd4);
        push_item(OP_CLEAR, '0, '0, '0, '0, '0, '0);
        push_item(OP_QUERY, a, 64'd0, a, a, '0, '0);
        for (int i = 0; i < 30; i++)
            push_random_item();
    end

    // sender: bursts of random length separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_data    <= '0;
            gap_left   <= 0;
            burst_left <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_items.size() > 0)
            begin
                in_valid <= 1'b1;
                in_data  <= pending_items.pop_front();
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: out_ready follows a randomly re-chosen stall mode
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            cycle_cnt  <= 0;
            stall_mode <= 0;
        end
        else
        begin
            cycle_cnt <= cycle_cnt + 1;
            if (cycle_cnt % 150 == 149)
                stall_mode <= $urandom_range(3);
            case (stall_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= $urandom_range(1);
                2:       out_ready <= ($urandom_range(3) == 0);
                default: out_ready <= (cycle_cnt % 7) < 4;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            expected_results.push_back(table_lookup_result(in_data));
    end

    always @(posedge clk)
    begin
        ciit_out_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                unexpected++;
                if (mismatches + unexpected <= 10)
                    $display("unexpected result: %p", out_data);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (out_data !== exp_r)
                begin
                    mismatches++;
                    if (mismatches + unexpected <= 10)
                        $display("mismatch: status exp %0d got %0d, offset exp %h got %h, length exp %h got %h, count exp %0d got %0d",
                                 exp_r.status, out_data.status,
                                 exp_r.found_offset, out_data.found_offset,
                                 exp_r.found_length, out_data.found_length,
                                 exp_r.entry_count, out_data.entry_count);
                end
            end
        end
    end

    initial begin
        mismatches = 0;
        unexpected = 0;
        tbl_count  = 0;
        @(posedge rst_n);
        @(posedge clk);
        while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0 && unexpected == 0 && expected_results.size() == 0)
            $display("[chunk_id_index_table_unit] OK");
        else
            $display("[chunk_id_index_table_unit] ERROR");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("[chunk_id_index_table_unit] ERROR");
        $finish;
    end

endmodule
